// ===== rtl/drfm_pkg.sv =====
// drfm_pkg: types and constants of the drive fault retry monitor
// per-drive entry layout, request codes, drive state codes, csr indexes
// no dependencies
`default_nettype none

package drfm_pkg;

   // one drive entry as kept in the state memory
   typedef struct packed {
      logic [7:0]  retry_count;
      logic        locked_out;
      logic        reset_active;
      logic [63:0] healthy_since;
      logic [63:0] enabled_since;
   } entry_type;

   // request actions
   localparam logic ACT_STEP  = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   // drive state codes
   localparam logic [1:0] DS_OTHER          = 2'd0;
   localparam logic [1:0] DS_OP_ENABLED     = 2'd1;
   localparam logic [1:0] DS_FAULT_REACTION = 2'd2;
   localparam logic [1:0] DS_FAULT          = 2'd3;

   // csr indexes
   localparam logic [1:0] CSR_DRIVE_COUNT   = 2'd0;
   localparam logic [1:0] CSR_RETRY_BUDGET  = 2'd1;
   localparam logic [1:0] CSR_STABLE_CLEAR  = 2'd2;
   localparam logic [1:0] CSR_HEALTHY_FORGET = 2'd3;

   // csr reset values
   localparam logic [4:0]  DRIVE_COUNT_RST    = 5'd0;
   localparam logic [7:0]  RETRY_BUDGET_RST   = 8'd3;
   localparam logic [31:0] STABLE_CLEAR_RST   = 32'd1000;
   localparam logic [31:0] HEALTHY_FORGET_RST = 32'd10000;

endpackage

`default_nettype wire

// ===== rtl/drfm_ram.sv =====
// drfm_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies
`default_nettype none

module drfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/drive_fault_retry_monitor.sv =====
// drive_fault_retry_monitor: fault retry and lockout tracking for a set of servo drives
// depends on drfm_pkg and drfm_ram
//
// Usage:
//   A request (req_* ports) is taken at a rising edge with start high and busy low.
//   action step updates one drive from its state, timestamp and reset handshake;
//   action clear releases that drive's lockout. Exactly one response follows
//   each request: rsp_strobe is high for one cycle with the seven flags.
//   The request edge reads the drive entry from the state ram, the next
//   cycle (busy high) computes and writes the entry back, and the response
//   shows in the cycle after that. A new request is taken only after the
//   read-modify-write of the single state ram is through; busy is high for
//   the one cycle in between, so two requests never touch the ram at once.
//   The receiver cannot stall: rsp_strobe lasts one cycle only.
//   csr_* is a plain write port (index 0 drive_count, 1 retry_budget,
//   2 stable_clear_cycles, 3 healthy_forget_cycles), written while idle.
//   Reset loads csr defaults and clears all drive entries; a drive_count write
//   clears all entries too. Both act at once through per-entry valid bits,
//   so no clearing pass is needed.
`default_nettype none

module drive_fault_retry_monitor #(
   parameter int DRIVES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_action,
   input  wire logic [7:0]  req_drive_index,
   input  wire logic [1:0]  req_drive_state,
   input  wire logic [63:0] req_cycle_now,
   input  wire logic        req_reset_cleared,
   input  wire logic        req_reset_pending,
   // response channel
   output logic             rsp_strobe,
   output logic             rsp_drive_off,
   output logic             rsp_first_fault,
   output logic             rsp_lockout_now,
   output logic             rsp_all_clear_rehome,
   output logic             rsp_seed_position,
   output logic             rsp_skip_enable,
   output logic             rsp_start_reset,
   // configuration port
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wr_data
);

   localparam int IDX_W = (DRIVES > 1) ? $clog2(DRIVES) : 1;
   localparam logic [7:0] DRIVES_LIM = 8'(DRIVES);

   typedef enum logic {
      ST_IDLE,
      ST_CALC
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [4:0]  drive_count_ff;
   logic [7:0]  retry_budget_ff;
   logic [31:0] stable_clear_ff;
   logic [31:0] healthy_forget_ff;

   // per-drive flags kept in flops: entry valid and fault seen
   logic [DRIVES-1:0] valid_ff;
   logic [DRIVES-1:0] fault_ff;

   // latched request
   logic        action_ff;
   logic [7:0]  idx_ff;
   logic [1:0]  dstate_ff;
   logic [63:0] now_ff;
   logic        cleared_ff;
   logic        pending_ff;

   // registered response
   logic rsp_strobe_ff;
   logic off_ff, first_ff, lock_ff, rehome_ff, seed_ff, skip_ff, start_ff;

   logic                       accept;
   logic [IDX_W-1:0]           idx_lo;
   logic [$bits(drfm_pkg::entry_type)-1:0] ram_rd_data;
   drfm_pkg::entry_type        rd_entry;
   drfm_pkg::entry_type        wr_entry;
   logic                       wr_en;
   logic                       in_range;
   logic                       fs_in;
   logic [DRIVES-1:0]          others_faulted;
   logic                       none_faulted;
   logic [63:0]                en_eff;
   logic                       done;
   logic off_in, first_in, lock_in, rehome_in, seed_in, skip_in, start_in;

   assign accept = start && !busy;
   assign busy   = (state_ff == ST_CALC);
   assign idx_lo = idx_ff[IDX_W-1:0];

   // state memory: one entry per drive
   drfm_ram #(
      .WIDTH ($bits(drfm_pkg::entry_type)),
      .DEPTH (DRIVES)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_lo),
      .wr_data (wr_entry),
      .rd_en   (accept),
      .rd_addr (req_drive_index[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // an entry not written since the last clear reads as zero
   assign rd_entry = valid_ff[idx_lo] ? drfm_pkg::entry_type'(ram_rd_data)
                                      : drfm_pkg::entry_type'('0);

   assign in_range = (idx_ff < {3'b000, drive_count_ff}) && (idx_ff < DRIVES_LIM);

   // faults of the other monitored drives
   always_comb begin
      for (int j = 0; j < DRIVES; j++) begin
         others_faulted[j] = fault_ff[j] && (7'(j) < {2'b00, drive_count_ff})
                             && (8'(j) != idx_ff);
      end
   end
   assign none_faulted = ~|others_faulted;

   // drive update
   always_comb begin
      wr_entry  = rd_entry;
      fs_in     = fault_ff[idx_lo];
      wr_en     = 1'b0;
      done      = 1'b0;
      en_eff    = rd_entry.enabled_since;
      off_in    = 1'b0;
      first_in  = 1'b0;
      lock_in   = 1'b0;
      rehome_in = 1'b0;
      seed_in   = 1'b0;
      skip_in   = 1'b0;
      start_in  = 1'b0;
      if (busy && in_range) begin
         if (action_ff == drfm_pkg::ACT_CLEAR) begin
            wr_en                 = 1'b1;
            wr_entry.locked_out   = 1'b0;
            wr_entry.retry_count  = '0;
            wr_entry.reset_active = 1'b0;
            fs_in                 = 1'b0;
         end else if (rd_entry.locked_out) begin
            off_in = 1'b1;
         end else if (dstate_ff == drfm_pkg::DS_FAULT ||
                      dstate_ff == drfm_pkg::DS_FAULT_REACTION) begin
            wr_en = 1'b1;
            // new fault episode
            if (!fs_in) begin
               fs_in                 = 1'b1;
               wr_entry.reset_active = 1'b0;
               first_in              = 1'b1;
            end
            if (dstate_ff == drfm_pkg::DS_FAULT) begin
               if (rd_entry.retry_count >= retry_budget_ff) begin
                  // budget used up: lock the drive out
                  wr_entry.locked_out = 1'b1;
                  lock_in             = 1'b1;
                  off_in              = 1'b1;
                  done                = 1'b1;
               end else begin
                  if (!wr_entry.reset_active) begin
                     wr_entry.reset_active = 1'b1;
                     wr_entry.retry_count  = rd_entry.retry_count + 8'd1;
                     start_in              = 1'b1;
                  end
                  if (cleared_ff) begin
                     wr_entry.reset_active  = 1'b0;
                     wr_entry.enabled_since = '0;
                     wr_entry.healthy_since = now_ff;
                     fs_in                  = 1'b0;
                     rehome_in              = none_faulted;
                     seed_in                = 1'b1;
                     done                   = 1'b1;
                  end else if (!pending_ff) begin
                     wr_entry.reset_active = 1'b0;
                  end
               end
            end
            skip_in = !done;
         end else begin
            wr_en = 1'b1;
            // self recovery after a stable operation-enabled time
            if (fs_in) begin
               if (dstate_ff == drfm_pkg::DS_OP_ENABLED) begin
                  if (rd_entry.enabled_since == 64'd0) begin
                     en_eff = now_ff;
                  end
                  wr_entry.enabled_since = en_eff;
                  if ((now_ff - en_eff) >= {32'd0, stable_clear_ff}) begin
                     fs_in                  = 1'b0;
                     wr_entry.reset_active  = 1'b0;
                     wr_entry.healthy_since = now_ff;
                     rehome_in              = none_faulted;
                  end
               end else begin
                  wr_entry.enabled_since = '0;
               end
            end
            // forget retries after a long healthy interval
            if (wr_entry.retry_count != 8'd0 && wr_entry.healthy_since != 64'd0 &&
                (now_ff - wr_entry.healthy_since) > {32'd0, healthy_forget_ff}) begin
               wr_entry.retry_count = '0;
            end
         end
      end
   end

   // request payload capture
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff  <= req_action;
         idx_ff     <= req_drive_index;
         dstate_ff  <= req_drive_state;
         now_ff     <= req_cycle_now;
         cleared_ff <= req_reset_cleared;
         pending_ff <= req_reset_pending;
      end
   end

   // control state, configuration, per-drive flags and response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         drive_count_ff    <= drfm_pkg::DRIVE_COUNT_RST;
         retry_budget_ff   <= drfm_pkg::RETRY_BUDGET_RST;
         stable_clear_ff   <= drfm_pkg::STABLE_CLEAR_RST;
         healthy_forget_ff <= drfm_pkg::HEALTHY_FORGET_RST;
         valid_ff          <= '0;
         fault_ff          <= '0;
         rsp_strobe_ff     <= 1'b0;
         off_ff            <= 1'b0;
         first_ff          <= 1'b0;
         lock_ff           <= 1'b0;
         rehome_ff         <= 1'b0;
         seed_ff           <= 1'b0;
         skip_ff           <= 1'b0;
         start_ff          <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_CALC;
               end
            end
            ST_CALC: begin
               state_ff      <= ST_IDLE;
               rsp_strobe_ff <= 1'b1;
               off_ff        <= off_in;
               first_ff      <= first_in;
               lock_ff       <= lock_in;
               rehome_ff     <= rehome_in;
               seed_ff       <= seed_in;
               skip_ff       <= skip_in;
               start_ff      <= start_in;
               if (wr_en) begin
                  valid_ff[idx_lo] <= 1'b1;
                  fault_ff[idx_lo] <= fs_in;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         // csr writes
         if (csr_wr_en) begin
            unique case (csr_index)
               drfm_pkg::CSR_DRIVE_COUNT: begin
                  drive_count_ff <= csr_wr_data[4:0];
                  valid_ff       <= '0;
                  fault_ff       <= '0;
               end
               drfm_pkg::CSR_RETRY_BUDGET:   retry_budget_ff   <= csr_wr_data[7:0];
               drfm_pkg::CSR_STABLE_CLEAR:   stable_clear_ff   <= csr_wr_data;
               drfm_pkg::CSR_HEALTHY_FORGET: healthy_forget_ff <= csr_wr_data;
               default: ;
            endcase
         end
      end
   end

   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_drive_off        = off_ff;
   assign rsp_first_fault      = first_ff;
   assign rsp_lockout_now      = lock_ff;
   assign rsp_all_clear_rehome = rehome_ff;
   assign rsp_seed_position    = seed_ff;
   assign rsp_skip_enable      = skip_ff;
   assign rsp_start_reset      = start_ff;

`ifndef ASSERT_OFF
   // a request is followed by exactly one compute cycle
   a_accept_calc: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("request not followed by compute cycle");

   a_calc_single: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy && rsp_strobe)
      else $error("compute cycle not followed by response");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !busy |=> !rsp_strobe)
      else $error("response without request");

   a_lock_off: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_lockout_now |-> rsp_drive_off && !rsp_skip_enable)
      else $error("lockout response without drive off");

   a_seed_noskip: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_seed_position |-> !rsp_skip_enable && !rsp_drive_off)
      else $error("seed response with skip or drive off");
`endif

endmodule

`default_nettype wire
